// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, masked while reset is high
`define ASSERT_ON(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property, live during reset too
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/tdcm_pkg.sv
package tdcm_pkg;

  localparam int SAMPLE_BITS      = 24;
  localparam int MAX_BLOCK_FRAMES = 4096;

  localparam int GAIN_W     = 16;
  localparam int STEP_W     = 17;
  localparam int FRAC_BITS  = 12;
  localparam int IDX_W      = (MAX_BLOCK_FRAMES > 1) ? $clog2(MAX_BLOCK_FRAMES) : 1;
  localparam int T_W        = IDX_W + STEP_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = STEP_W;
  localparam int QUEUE_DEPTH = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUE_A    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CUE_B    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CUE_EN   = 3'd5;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1) << (STEP_W - 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [GAIN_W-1:0] gain_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    gain_t               target_a;
    gain_t               target_b;
    gain_t               cue_a;
    gain_t               cue_b;
    logic [STEP_W-1:0]   step;
    logic                cue_en;
  } cfg_t;

  // one queued frame plus the block position and ramp start gains it was taken at
  typedef struct packed {
    sample_t al;
    sample_t ar;
    sample_t bl;
    sample_t br;
    idx_t    idx;
    gain_t   start_a;
    gain_t   start_b;
  } item_t;

endpackage

// File: hw/rtl/tdcm_if.sv
interface tdcm_frame_if import tdcm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t deck_a_left;
  sample_t deck_a_right;
  sample_t deck_b_left;
  sample_t deck_b_right;
  logic    block_end;

  modport source(output valid, deck_a_left, deck_a_right, deck_b_left, deck_b_right,
                 block_end, input ready);
  modport sink(input valid, deck_a_left, deck_a_right, deck_b_left, deck_b_right,
               block_end, output ready);
endinterface

interface tdcm_mix_if import tdcm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t master_left;
  sample_t master_right;
  sample_t cue_left;
  sample_t cue_right;

  modport source(output valid, master_left, master_right, cue_left, cue_right,
                 input ready);
  modport sink(input valid, master_left, master_right, cue_left, cue_right,
               output ready);
endinterface

// File: hw/rtl/tdcm_front.sv
module tdcm_front import tdcm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  tdcm_frame_if.sink    deck_in,
  input  cfg_t          cfg,
  input  logic          queue_full,
  output logic          push,
  output item_t         push_data
);

  localparam idx_t IDX_LAST = IDX_W'(MAX_BLOCK_FRAMES - 1);

  idx_t  frame_index;
  gain_t start_gain_a;
  gain_t start_gain_b;

  assign deck_in.ready = !queue_full;
  assign push          = deck_in.valid && !queue_full;

  assign push_data.al      = deck_in.deck_a_left;
  assign push_data.ar      = deck_in.deck_a_right;
  assign push_data.bl      = deck_in.deck_b_left;
  assign push_data.br      = deck_in.deck_b_right;
  assign push_data.idx     = frame_index;
  assign push_data.start_a = start_gain_a;
  assign push_data.start_b = start_gain_b;

  // block position and ramp start gains
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_index  <= '0;
      start_gain_a <= '0;
      start_gain_b <= '0;
    end else if (push) begin
      if (deck_in.block_end) begin
        frame_index  <= '0;
        start_gain_a <= cfg.target_a;
        start_gain_b <= cfg.target_b;
      end else if (frame_index != IDX_LAST) begin
        frame_index <= frame_index + idx_t'(1);
      end
    end
  end

endmodule

// File: hw/rtl/tdcm_queue.sv
module tdcm_queue import tdcm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: hw/rtl/tdcm_back.sv
module tdcm_back import tdcm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        head_valid,
  input  item_t       head,
  output logic        pop,
  tdcm_mix_if.source  mix_out
);

  localparam int ACC_W  = SAMPLE_BITS + GAIN_W + 2;
  localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
  localparam int RAMP_W = GAIN_W + T_W + 2;
  localparam int T_FRAC = STEP_W - 1;
  localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX =
    ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TIME = 3'd1;
  localparam logic [2:0] S_RAMP = 3'd2;
  localparam logic [2:0] S_ML   = 3'd3;
  localparam logic [2:0] S_MR   = 3'd4;
  localparam logic [2:0] S_CL   = 3'd5;
  localparam logic [2:0] S_CR   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]                state;
  item_t                     cur;
  logic [T_W-1:0]            t;
  gain_t                     gain_a;
  gain_t                     gain_b;
  logic signed [ACC_W-1:0]   acc;
  sample_t                   res_ml;
  sample_t                   res_mr;
  sample_t                   res_cl;
  logic                      out_valid;

  sample_t                   mix_x;
  sample_t                   mix_y;
  gain_t                     mix_g1;
  gain_t                     mix_g2;
  logic signed [PROD_W-1:0]  prod_1;
  logic signed [PROD_W-1:0]  prod_2;
  logic signed [ACC_W-1:0]   mix_sum;
  gain_t                     cue_ga;
  gain_t                     cue_gb;
  logic                      out_free;

  // floor shift to Q1.23 and clamp
  function automatic sample_t sat_sample(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] s;
    s = v >>> FRAC_BITS;
    if (s > SAT_MAX) begin
      s = SAT_MAX;
    end else if (s < SAT_MIN) begin
      s = SAT_MIN;
    end
    sat_sample = s[SAMPLE_BITS-1:0];
  endfunction

  // start + floor((target - start) * t / 2^16), clamped to the gain range
  function automatic gain_t ramp(input gain_t start, input gain_t target,
                                 input logic [T_W-1:0] tt);
    logic signed [GAIN_W:0]     delta;
    logic signed [RAMP_W-1:0]   prod;
    logic signed [RAMP_W-1:0]   g;
    delta = $signed({1'b0, target}) - $signed({1'b0, start});
    prod  = RAMP_W'(delta) * $signed({{(RAMP_W-T_W){1'b0}}, tt});
    g     = $signed({{(RAMP_W-GAIN_W){1'b0}}, start}) + (prod >>> T_FRAC);
    if (g < 0) begin
      ramp = '0;
    end else if (g > $signed(RAMP_W'({GAIN_W{1'b1}}))) begin
      ramp = '1;
    end else begin
      ramp = g[GAIN_W-1:0];
    end
  endfunction

  // a disabled cue mixes with zero gain, which rounds to zero
  assign cue_ga = cfg.cue_en ? cfg.cue_a : '0;
  assign cue_gb = cfg.cue_en ? cfg.cue_b : '0;

  always_comb begin
    unique case (state)
      S_MR, S_CR: begin
        mix_x = cur.ar;
        mix_y = cur.br;
      end
      default: begin
        mix_x = cur.al;
        mix_y = cur.bl;
      end
    endcase
    unique case (state)
      S_CL, S_CR: begin
        mix_g1 = cue_ga;
        mix_g2 = cue_gb;
      end
      default: begin
        mix_g1 = gain_a;
        mix_g2 = gain_b;
      end
    endcase
  end

  assign prod_1  = mix_x * $signed({1'b0, mix_g1});
  assign prod_2  = mix_y * $signed({1'b0, mix_g2});
  assign mix_sum = ACC_W'(prod_1) + ACC_W'(prod_2) + ROUND;

  assign pop      = (state == S_IDLE) && head_valid;
  assign out_free = !out_valid || mix_out.ready;

  assign mix_out.valid = out_valid;

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (head_valid) begin
          cur <= head;
        end
      end
      S_TIME: begin
        t <= T_W'(cur.idx) * T_W'(cfg.step);
      end
      S_RAMP: begin
        gain_a <= ramp(cur.start_a, cfg.target_a, t);
        gain_b <= ramp(cur.start_b, cfg.target_b, t);
      end
      S_ML: begin
        acc <= mix_sum;
      end
      S_MR: begin
        res_ml <= sat_sample(acc);
        acc    <= mix_sum;
      end
      S_CL: begin
        res_mr <= sat_sample(acc);
        acc    <= mix_sum;
      end
      S_CR: begin
        res_cl <= sat_sample(acc);
        acc    <= mix_sum;
      end
      S_DONE: begin
        if (out_free) begin
          mix_out.master_left  <= res_ml;
          mix_out.master_right <= res_mr;
          mix_out.cue_left     <= res_cl;
          mix_out.cue_right    <= sat_sample(acc);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (mix_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (head_valid) begin
            state <= S_TIME;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= state + 3'd1;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/two_deck_crossfade_mixer.sv
// channel     | dir | transfer when       | payload
// deck_in     | in  | valid && ready      | four deck samples, block_end
// mix_out     | out | valid && ready      | master pair, cue pair
// cfg         | in  | cfg_we              | cfg_index selects register, cfg_data
//
// the back-end sequencer takes each frame through load, ramp time, ramp gains,
// then one stereo product pair per step for master left/right and cue left/right
// and a final step into the output register
// sync reset clears config, ramp state, queue and output valid; no clearing pass
// a two-entry queue lets the front take frames while the back end works, and the
// output register holds a finished result while the sink stalls
module two_deck_crossfade_mixer import tdcm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  tdcm_frame_if.sink             deck_in,
  tdcm_mix_if.source             mix_out,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t  cfg;
  logic  push;
  item_t push_data;
  logic  queue_full;
  logic  pop;
  logic  head_valid;
  item_t head;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_a <= '0;
      cfg.target_b <= '0;
      cfg.cue_a    <= '0;
      cfg.cue_b    <= '0;
      cfg.step     <= STEP_RESET;
      cfg.cue_en   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_A: cfg.target_a <= cfg_data[GAIN_W-1:0];
        REG_TARGET_B: cfg.target_b <= cfg_data[GAIN_W-1:0];
        REG_CUE_A:    cfg.cue_a    <= cfg_data[GAIN_W-1:0];
        REG_CUE_B:    cfg.cue_b    <= cfg_data[GAIN_W-1:0];
        REG_STEP:     cfg.step     <= cfg_data[STEP_W-1:0];
        REG_CUE_EN:   cfg.cue_en   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // front: takes frames, tracks block position and start gains
  tdcm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .deck_in    (deck_in),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  // decouples front and back
  tdcm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: ramp gains, mixes and saturates, owns the output register
  tdcm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .mix_out    (mix_out)
  );

endmodule

// File: hw/rtl/tdcm_checker.sv
`include "assert_macros.svh"

module tdcm_checker import tdcm_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input sample_t                cue_left,
  input sample_t                cue_right,
  input logic                   cfg_we,
  input logic [CFG_IDX_W-1:0]   cfg_index,
  input logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [2:0] pending;
  logic       cue_on;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // frames taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending <= pending + 3'd1;
    end else if (out_xfer && !in_xfer) begin
      pending <= pending - 3'd1;
    end
  end

  // shadow of the cue enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      cue_on <= 1'b0;
    end else if (cfg_we && cfg_index == REG_CUE_EN) begin
      cue_on <= cfg_data[0];
    end
  end

  `ASSERT_ON(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped")
  `ASSERT_ON(a_no_invented, clk, rst, out_valid |-> pending != 3'd0, "result with no frame")
  `ASSERT_ON(a_cue_off, clk, rst, out_valid && !cue_on |-> cue_left == '0 && cue_right == '0, "cue not zero")
  `ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid, "output valid after reset")

endmodule

bind two_deck_crossfade_mixer tdcm_checker u_tdcm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (deck_in.valid),
  .in_ready  (deck_in.ready),
  .out_valid (mix_out.valid),
  .out_ready (mix_out.ready),
  .cue_left  (mix_out.cue_left),
  .cue_right (mix_out.cue_right),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);
